// ----- sv/fdss_pkg.sv -----
// shared types, constants and the segment decoder for the digit scanner
`default_nettype none
package fdss_pkg;

  localparam int unsigned VALUE_W = 14;
  localparam int unsigned SEG_W   = 7;
  localparam int unsigned DIGITS  = 4;
  localparam int unsigned CNT_W   = 2;
  localparam int unsigned QUOT_W  = 10;

  localparam logic [VALUE_W-1:0] OVERFLOW_LIMIT = 14'd9999;
  // reciprocal of ten scaled by 2^16, exact for values up to the limit
  localparam logic [12:0]        RECIP_TEN      = 13'd6554;
  localparam int unsigned        RECIP_SHIFT    = 16;

  localparam logic [SEG_W-1:0]   SEG_ZERO       = 7'h3F;
  localparam logic [DIGITS-1:0]  ALL_DIGITS     = 4'hF;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic div;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic ovf;
    logic q_zero;
  } status_t;

  function automatic logic [SEG_W-1:0] seg_decode(input logic [3:0] d);
    logic [SEG_W-1:0] s;
    case (d)
      4'd0:    s = 7'h3F;
      4'd1:    s = 7'h06;
      4'd2:    s = 7'h5B;
      4'd3:    s = 7'h4F;
      4'd4:    s = 7'h66;
      4'd5:    s = 7'h6D;
      4'd6:    s = 7'h7D;
      4'd7:    s = 7'h07;
      4'd8:    s = 7'h7F;
      4'd9:    s = 7'h6F;
      default: s = 7'h00;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

// ----- sv/fdss_ctrl.sv -----
// sequencing state machine for the digit scanner
`default_nettype none
module fdss_ctrl (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_valid,
  output logic             in_ready,
  input  fdss_pkg::status_t sts,
  output fdss_pkg::cmd_t   cmd
);

  fdss_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fdss_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      fdss_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = fdss_pkg::ST_DIV;
        end
      end
      fdss_pkg::ST_DIV: begin
        cmd.div   = 1'b1;
        state_nxt = fdss_pkg::ST_EMIT;
      end
      fdss_pkg::ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.ovf || sts.q_zero) begin
            state_nxt = fdss_pkg::ST_IDLE;
          end else begin
            state_nxt = fdss_pkg::ST_DIV;
          end
        end
      end
      default: begin
        state_nxt = fdss_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- sv/fdss_dp.sv -----
// value register, divide-by-ten step, enable mask and output register
`default_nettype none
module fdss_dp (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire [fdss_pkg::VALUE_W-1:0]       in_value_to_show,
  input  fdss_pkg::cmd_t                    cmd,
  output fdss_pkg::status_t                 sts,
  output logic                              out_valid,
  input  wire                               out_ready,
  output logic [fdss_pkg::SEG_W-1:0]        out_segments,
  output logic [fdss_pkg::DIGITS-1:0]       out_digit_enables,
  output logic                              out_last
);

  logic [fdss_pkg::VALUE_W-1:0]  val_r;
  logic [fdss_pkg::QUOT_W-1:0]   quot_r;
  logic                          ovf_r;
  logic [fdss_pkg::CNT_W-1:0]    cnt_r;
  logic [fdss_pkg::DIGITS-1:0]   held_r;
  logic                          out_valid_r;
  logic [fdss_pkg::SEG_W-1:0]    seg_r;
  logic [fdss_pkg::DIGITS-1:0]   en_r;
  logic                          last_r;

  logic [26:0]                   prod;
  logic [fdss_pkg::VALUE_W-1:0]  rem_full;
  logic [3:0]                    digit;
  logic [fdss_pkg::DIGITS-1:0]   pos_bit;

  // quotient by reciprocal multiply
  assign prod = 27'(val_r) * 27'(fdss_pkg::RECIP_TEN);

  // remainder = v - 10*q using shifts
  assign rem_full = val_r
                  - {1'b0, quot_r, 3'b000}
                  - {3'b000, quot_r, 1'b0};
  assign digit    = rem_full[3:0];

  // first digit lands on the rightmost position (bit 3)
  always_comb begin
    pos_bit = '0;
    pos_bit[fdss_pkg::CNT_W'(fdss_pkg::DIGITS - 1) - cnt_r] = 1'b1;
  end

  assign sts.out_free = !out_valid_r || out_ready;
  assign sts.ovf      = ovf_r;
  assign sts.q_zero   = (quot_r == '0);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      val_r <= in_value_to_show;
    end else if (cmd.emit) begin
      val_r <= fdss_pkg::VALUE_W'(quot_r);
    end
    if (cmd.div) begin
      quot_r <= prod[fdss_pkg::RECIP_SHIFT +: fdss_pkg::QUOT_W];
    end
    if (cmd.load) begin
      ovf_r <= (in_value_to_show > fdss_pkg::OVERFLOW_LIMIT);
    end
    if (cmd.emit) begin
      if (ovf_r) begin
        seg_r  <= fdss_pkg::SEG_ZERO;
        en_r   <= fdss_pkg::ALL_DIGITS;
        last_r <= 1'b1;
      end else begin
        seg_r  <= fdss_pkg::seg_decode(digit);
        en_r   <= held_r | pos_bit;
        last_r <= (quot_r == '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        cnt_r <= '0;
      end else if (cmd.emit) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (cmd.emit) begin
        if (ovf_r) begin
          held_r <= fdss_pkg::ALL_DIGITS;
        end else begin
          held_r <= held_r & ~pos_bit;
        end
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_segments      = seg_r;
  assign out_digit_enables = en_r;
  assign out_last          = last_r;

endmodule
`default_nettype wire

// ----- sv/four_digit_seven_segment_scanner_unit.sv -----
// top level of the four-digit seven-segment scanner
// Takes one 14-bit value per item and returns one result item per lit digit,
// least significant digit first, placed from the rightmost digit (enable
// bit 3) leftward with no leading zeros; zero gives a single '0'. Each
// result's enable mask is the held mask plus the current digit, and that
// digit's bit is then cleared from the held mask. A value above 9999 gives
// one result showing '0' with all four enables set, and the held mask is
// left all ones. out_last marks the final result of an item.
// Sequence: an item is taken in the idle state, then each digit takes a
// divide-by-ten step through a constant reciprocal multiplier, then the
// load of the output register, which waits for out_ready while that
// register still holds an untaken result. The next item is taken once the
// last result is in the output register, while that result may still be
// waiting.
`default_nettype none
module four_digit_seven_segment_scanner_unit (
  input  wire                               clk,
  input  wire                               rst_n,
  // input channel
  input  wire                               in_valid,
  output logic                              in_ready,
  input  wire [fdss_pkg::VALUE_W-1:0]       in_value_to_show,
  // result channel
  output logic                              out_valid,
  input  wire                               out_ready,
  output logic [fdss_pkg::SEG_W-1:0]        out_segments,
  output logic [fdss_pkg::DIGITS-1:0]       out_digit_enables,
  output logic                              out_last
);

  // command and status between sequencer and datapath
  fdss_pkg::cmd_t    cmd;
  fdss_pkg::status_t sts;

  fdss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  fdss_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_value_to_show  (in_value_to_show),
    .cmd               (cmd),
    .sts               (sts),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_segments      (out_segments),
    .out_digit_enables (out_digit_enables),
    .out_last          (out_last)
  );

endmodule
`default_nettype wire
